@@ rtl/core/fixed_block_pool_allocator_macros.svh @@
// Assertion macros used by the allocator RTL.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FBPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FBPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/fbpa_pkg.sv @@
package fbpa_pkg;

    localparam int MAX_BLOCKS_DEF = 1024;
    localparam int ADDR_WIDTH_DEF = 32;

    localparam int BSL_W   = 5;
    localparam int BASE_W  = 32;
    localparam int COUNT_W = 11;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [BSL_W-1:0]   BSL_RESET   = 5'd6;
    localparam logic [BASE_W-1:0]  BASE_RESET  = 32'd0;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT     = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] STATUS_ALLOCATED = 2'd0;
    localparam logic [1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [1:0] STATUS_FREED     = 2'd2;
    localparam logic [1:0] STATUS_RANGE     = 2'd3;

    typedef struct packed {
        logic        operation;
        logic [31:0] free_address;
    } in_item_t;

    typedef struct packed {
        logic [31:0] block_address;
        logic [1:0]  status;
    } out_item_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } fbpa_state_t;

endpackage

@@ rtl/core/fbpa_link_mem.sv @@
module fbpa_link_mem #(
    parameter int DEPTH  = fbpa_pkg::MAX_BLOCKS_DEF,
    parameter int DATA_W = $clog2(fbpa_pkg::MAX_BLOCKS_DEF) + 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    // Each entry holds the tail flag above the link to the next list entry.
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/fixed_block_pool_allocator.sv @@
// A transfer accepted in IDLE is captured, worked in EXEC and its result is then registered in
// the output register; a stalled result keeps the sequencer waiting until it is taken.
// A new request is taken only in IDLE, once the last one has left EXEC, so the registered
// read of the link memory returns the free-list head before the next pop can use it.
// Reset (rst_n, asynchronous, active low) restores the register defaults and empties the pool;
// the link memory is not cleared and needs no clearing pass.
module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF,
    parameter int ADDR_WIDTH = fbpa_pkg::ADDR_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port.
    input  logic                               cfg_write,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbpa_pkg::CFG_W-1:0]         cfg_data,
    // Request channel.
    input  logic                               in_valid,
    output logic                               in_stall,
    input  fbpa_pkg::in_item_t                 in_data,
    // Result channel.
    output logic                               out_valid,
    input  logic                               out_stall,
    output fbpa_pkg::out_item_t                out_data
);

    `include "fixed_block_pool_allocator_macros.svh"

    // Index width for the pool and counter width that can also hold the block count.
    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int CW    = (CNT_W > fbpa_pkg::COUNT_W) ? CNT_W : fbpa_pkg::COUNT_W;
    localparam int CMPW  = (ADDR_WIDTH > CNT_W) ? ADDR_WIDTH : CNT_W;
    localparam int LNK_W = IDX_W + 1;

    // Configuration registers.
    logic [fbpa_pkg::BSL_W-1:0]   bsl_reg;
    logic [fbpa_pkg::BASE_W-1:0]  base_reg;
    logic [fbpa_pkg::COUNT_W-1:0] count_reg;
    logic                         reinit;

    // Pool state.
    logic [CNT_W-1:0] next_unused_reg, next_unused_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic             nonempty_reg, nonempty_next;

    // Sequencer and captured request.
    fbpa_pkg::fbpa_state_t state_reg, state_next;
    logic                  op_reg;
    logic                  below_reg;
    logic [ADDR_WIDTH-1:0] diff_reg;
    logic                  exec_go;
    logic                  accept;

    // Result register.
    logic                  out_valid_reg;
    fbpa_pkg::out_item_t   out_data_reg, result;

    // Link memory interface.
    logic             lnk_we;
    logic [IDX_W-1:0] lnk_waddr;
    logic [LNK_W-1:0] lnk_wdata;
    logic [LNK_W-1:0] lnk_rdata;

    // Datapath.
    logic [CW-1:0]         count_wide;
    logic [CNT_W-1:0]      count_eff;
    logic                  fresh_avail;
    logic [IDX_W-1:0]      pop_link;
    logic                  pop_last;
    logic [ADDR_WIDTH-1:0] sel_index;
    logic [ADDR_WIDTH-1:0] alloc_addr;
    logic [ADDR_WIDTH-1:0] free_idx;
    logic                  free_ok;

    // ------------------------------------------------------------------
    // Configuration. Any write to a known register reinitializes the pool.
    // ------------------------------------------------------------------
    always_comb
    begin
        reinit = 1'b0;
        if (cfg_write)
        begin
            unique case (cfg_index)
                fbpa_pkg::REG_BLOCK_SIZE_LOG2,
                fbpa_pkg::REG_REGION_BASE,
                fbpa_pkg::REG_BLOCK_COUNT: reinit = 1'b1;
                default:                   reinit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bsl_reg   <= fbpa_pkg::BSL_RESET;
            base_reg  <= fbpa_pkg::BASE_RESET;
            count_reg <= fbpa_pkg::COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                fbpa_pkg::REG_BLOCK_SIZE_LOG2: bsl_reg   <= cfg_data[fbpa_pkg::BSL_W-1:0];
                fbpa_pkg::REG_REGION_BASE:     base_reg  <= cfg_data[fbpa_pkg::BASE_W-1:0];
                fbpa_pkg::REG_BLOCK_COUNT:     count_reg <= cfg_data[fbpa_pkg::COUNT_W-1:0];
                default:                       ;
            endcase
        end
    end

    // A block count above the pool capacity is clamped to the capacity.
    always_comb
    begin
        count_wide = CW'(count_reg);
        if (count_wide > CW'(MAX_BLOCKS))
        begin
            count_wide = CW'(MAX_BLOCKS);
        end
        count_eff = CNT_W'(count_wide);
    end

    // ------------------------------------------------------------------
    // Sequencer: a request is taken in IDLE, and its work is done in EXEC.
    // EXEC holds while the previous result still waits in the output register.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fbpa_pkg::S_IDLE: if (in_valid) state_next = fbpa_pkg::S_EXEC;
            fbpa_pkg::S_EXEC: if (exec_go)  state_next = fbpa_pkg::S_IDLE;
            default:          state_next = fbpa_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        exec_go  = 1'b0;
        unique case (state_reg)
            fbpa_pkg::S_IDLE: in_stall = 1'b0;
            fbpa_pkg::S_EXEC: exec_go  = !out_valid_reg || !out_stall;
            default:          in_stall = 1'b1;
        endcase
    end

    assign accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fbpa_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The subtraction for a free is done on the way in, leaving only the
    // shift and the range compare for the EXEC cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= in_data.operation;
            below_reg <= in_data.free_address < base_reg;
            diff_reg  <= ADDR_WIDTH'(in_data.free_address) - ADDR_WIDTH'(base_reg);
        end
    end

    // ------------------------------------------------------------------
    // Link memory. It is read at the current head every cycle, so the entry
    // of the head is ready in the cycle after the head last changed.
    // ------------------------------------------------------------------
    fbpa_link_mem #(
        .DEPTH  (MAX_BLOCKS),
        .DATA_W (LNK_W)
    ) u_link_mem (
        .clk   (clk),
        .we    (lnk_we),
        .waddr (lnk_waddr),
        .wdata (lnk_wdata),
        .raddr (head_reg),
        .rdata (lnk_rdata)
    );

    assign pop_last = lnk_rdata[LNK_W-1];
    assign pop_link = lnk_rdata[IDX_W-1:0];

    // ------------------------------------------------------------------
    // EXEC datapath.
    // ------------------------------------------------------------------
    assign fresh_avail = next_unused_reg < count_eff;
    assign sel_index   = fresh_avail ? ADDR_WIDTH'(next_unused_reg) : ADDR_WIDTH'(head_reg);
    assign alloc_addr  = ADDR_WIDTH'(base_reg) + (sel_index << bsl_reg);

    // Low offset bits drop out, so an address inside a block frees that block.
    assign free_idx = diff_reg >> bsl_reg;
    assign free_ok  = !below_reg && (CMPW'(free_idx) < CMPW'(count_eff));

    always_comb
    begin
        next_unused_next = next_unused_reg;
        head_next        = head_reg;
        nonempty_next    = nonempty_reg;
        lnk_we           = 1'b0;
        lnk_waddr        = IDX_W'(free_idx);
        lnk_wdata        = {!nonempty_reg, head_reg};
        result.block_address = '0;
        result.status        = fbpa_pkg::STATUS_EMPTY;

        if (op_reg == fbpa_pkg::OP_ALLOC)
        begin
            if (fresh_avail)
            begin
                result.block_address = 32'(alloc_addr);
                result.status        = fbpa_pkg::STATUS_ALLOCATED;
                next_unused_next     = next_unused_reg + CNT_W'(1);
            end
            else if (nonempty_reg)
            begin
                // Pop: the tail flag empties the list, otherwise follow the link.
                result.block_address = 32'(alloc_addr);
                result.status        = fbpa_pkg::STATUS_ALLOCATED;
                if (pop_last)
                begin
                    nonempty_next = 1'b0;
                end
                else
                begin
                    head_next = pop_link;
                end
            end
        end
        else if (free_ok)
        begin
            // Push: the old head becomes the link of the freed block.
            result.status = fbpa_pkg::STATUS_FREED;
            lnk_we        = exec_go;
            head_next     = IDX_W'(free_idx);
            nonempty_next = 1'b1;
        end
        else
        begin
            result.status = fbpa_pkg::STATUS_RANGE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_unused_reg <= '0;
            head_reg        <= '0;
            nonempty_reg    <= 1'b0;
        end
        else if (reinit)
        begin
            next_unused_reg <= '0;
            head_reg        <= '0;
            nonempty_reg    <= 1'b0;
        end
        else if (exec_go)
        begin
            next_unused_reg <= next_unused_next;
            head_reg        <= head_next;
            nonempty_reg    <= nonempty_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register. A new result enters when the old one is taken or absent.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `FBPA_ASSERT_NEXT(a_accept_to_exec, accept, state_reg == fbpa_pkg::S_EXEC, "accepted transfer did not start work")
    `FBPA_ASSERT_NOW(a_unused_bound, 1'b1, next_unused_reg <= count_eff, "fresh block counter passed the block count")
    `FBPA_ASSERT_NEXT(a_push_nonempty, exec_go && (result.status == fbpa_pkg::STATUS_FREED) && !reinit, nonempty_reg, "free list empty after a push")

endmodule
